@@ rtl/core/rstf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rstf_pkg: shared types and constants
// Item structs, register indexes and sequencer states for the
// retransmission store.
// ----------------------------------------------------------------------------
package rstf_pkg;

  localparam int unsigned Slots = 64;
  localparam int unsigned IdxW  = $clog2(Slots);
  localparam int unsigned CntW  = $clog2(Slots + 1);

  localparam logic [0:0] RegCapacity = 1'd0;
  localparam logic [0:0] RegTtl      = 1'd1;

  localparam logic OpStore = 1'b0;
  localparam logic OpGet   = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [15:0] seq_number;
    logic [31:0] packet_handle;
    logic [63:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] found_handle;
    logic [31:0] retransmitted_total;
    logic [31:0] miss_total;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StTtlRead,
    StTtlCheck,
    StCapTrim,
    StSearchRead,
    StSearchCheck,
    StApply,
    StDone
  } seq_state_e;

  // one slot word as kept in memory
  typedef struct packed {
    logic [15:0] seq;
    logic [63:0] stamp;
    logic [31:0] handle;
  } slot_t;

endpackage
`default_nettype wire

@@ rtl/core/retransmit_store_ttl_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// retransmit_store_ttl_fifo: retransmission store with TTL
// Ring of recently sent packets keyed by sequence number, with age and
// capacity eviction, store and lookup.
// ----------------------------------------------------------------------------
// Usage: pulse start while busy is low; busy rises at the next edge and
// the result appears on done_o for one cycle, with busy low again during it.
// The receiver cannot stall. One slot memory port and one 64-bit subtract and
// compare are shared by a sequencer: for each item it ages out expired entries
// from the head, stopping at the first live one, trims entries beyond the
// capacity, searches the remaining entries (at most 63) for the sequence
// number, then stores or looks up the item.
// Configuration writes take effect at once and belong in idle periods.
module retransmit_store_ttl_fifo
  import rstf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_item_i,
  output logic             done_o,
  output out_item_t        out_item_o,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  seq_state_e state_q, state_d;
  logic [5:0]      cap_q;
  logic [31:0]     ttl_q;
  logic [IdxW-1:0] head_q, head_d, tail_q, tail_d, ptr_q, ptr_d;
  logic [CntW-1:0] count_q, count_d, scan_q, scan_d;
  logic [31:0]     hits_q, hits_d, miss_q, miss_d;
  logic            found_q, found_d;
  logic [IdxW-1:0] fpos_q, fpos_d;
  logic [31:0]     fhandle_q, fhandle_d;
  in_item_t        item_q;
  out_item_t       out_q, out_d;
  logic            done_q, done_d;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  slot_t           wdata, rdata;
  logic [63:0]     age;
  logic [CntW-1:0] cap_eff;

  rstf_slot_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  function automatic logic [IdxW-1:0] nxt(input logic [IdxW-1:0] i);
    return (i == IdxW'(Slots - 1)) ? '0 : i + 1'b1;
  endfunction

  assign age     = item_q.now_ms - rdata.stamp;
  assign cap_eff = (CntW'(cap_q) > CntW'(Slots - 1)) ? CntW'(Slots - 1) : CntW'(cap_q);

  always_comb begin
    state_d = state_q; head_d = head_q; tail_d = tail_q; ptr_d = ptr_q;
    count_d = count_q; scan_d = scan_q; hits_d = hits_q; miss_d = miss_q;
    found_d = found_q; fpos_d = fpos_q; fhandle_d = fhandle_q;
    out_d = out_q; done_d = 1'b0;
    we = 1'b0; waddr = tail_q; raddr = head_q;
    wdata = '{seq: item_q.seq_number, stamp: item_q.now_ms, handle: item_q.packet_handle};
    unique case (state_q)
      StIdle: begin
        if (start) state_d = StTtlRead;
      end
      StTtlRead: begin
        raddr = head_q;
        state_d = (count_q == '0) ? StCapTrim : StTtlCheck;
      end
      StTtlCheck: begin
        if (age > {32'd0, ttl_q}) begin
          head_d  = nxt(head_q);
          count_d = count_q - 1'b1;
          raddr   = nxt(head_q);
          state_d = (count_q == CntW'(1)) ? StCapTrim : StTtlCheck;
        end else begin
          state_d = StCapTrim;
        end
      end
      StCapTrim: begin
        if (count_q > cap_eff) begin
          head_d  = nxt(head_q);
          count_d = count_q - 1'b1;
        end else begin
          ptr_d   = head_q;
          scan_d  = '0;
          found_d = 1'b0;
          state_d = StSearchRead;
        end
      end
      StSearchRead: begin
        raddr = ptr_q;
        state_d = (scan_q == count_q) ? StApply : StSearchCheck;
      end
      StSearchCheck: begin
        if (rdata.seq == item_q.seq_number) begin
          found_d   = 1'b1;
          fpos_d    = ptr_q;
          fhandle_d = rdata.handle;
          state_d   = StApply;
        end else begin
          ptr_d   = nxt(ptr_q);
          scan_d  = scan_q + 1'b1;
          state_d = StSearchRead;
        end
      end
      StApply: begin
        out_d = '0;
        if (item_q.operation == OpStore) begin
          if (found_q) begin
            we    = 1'b1;
            waddr = fpos_q;
            wdata = '{seq: item_q.seq_number, stamp: item_q.now_ms,
                      handle: item_q.packet_handle};
          end else begin
            we      = 1'b1;
            waddr   = tail_q;
            tail_d  = nxt(tail_q);
            count_d = count_q + 1'b1;
          end
        end else if (found_q) begin
          out_d.hit          = 1'b1;
          out_d.found_handle = fhandle_q;
          if (hits_q != '1) hits_d = hits_q + 1'b1;
        end else begin
          if (miss_q != '1) miss_d = miss_q + 1'b1;
        end
        state_d = StDone;
      end
      StDone: begin
        out_d.retransmitted_total = hits_q;
        out_d.miss_total          = miss_q;
        done_d  = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cap_q   <= 6'd63;
      ttl_q   <= 32'd1000;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      hits_q  <= '0;
      miss_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      hits_q  <= hits_d;
      miss_q  <= miss_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == RegCapacity) cap_q <= cfg_data_i[5:0];
        if (cfg_idx_i == RegTtl)      ttl_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) item_q <= in_item_i;
    ptr_q     <= ptr_d;
    scan_q    <= scan_d;
    found_q   <= found_d;
    fpos_q    <= fpos_d;
    fhandle_q <= fhandle_d;
    out_q     <= out_d;
  end

  assign busy       = (state_q != StIdle);
  assign done_o     = done_q;
  assign out_item_o = out_q;

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Slots))
    else $error("ring count above limit");
  a_ring_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> tail_q == IdxW'((head_q + count_q) % Slots))
    else $error("ring pointers inconsistent");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("done while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not start");

endmodule
`default_nettype wire

@@ rtl/core/rstf_slot_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rstf_slot_ram: slot store
// One write port and one registered read port holding sequence number,
// store time and handle for each slot.
// ----------------------------------------------------------------------------
module rstf_slot_ram
  import rstf_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [IdxW-1:0] waddr_i,
  input  wire slot_t           wdata_i,
  input  wire logic [IdxW-1:0] raddr_i,
  output slot_t                rdata_o
);

  slot_t mem [Slots];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire
